FILE: hdl/fqmm_pkg.sv
// Package with the shared types and codes of the byte queue with minimum and maximum report.
package fqmm_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [7:0] BYTE_MIN = 8'h00;
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
    } acc_t;

endpackage

FILE: hdl/fqmm_cell.sv
// One storage cell of the queue chain with its stage of the running minimum and maximum.
module fqmm_cell (
    input  logic                clk,
    input  fqmm_pkg::cell_ctrl_t ctrl,
    input  logic                held,
    input  logic                prev_held,
    input  logic [7:0]          next_data,
    input  fqmm_pkg::acc_t      acc_in,
    output logic [7:0]          data,
    output fqmm_pkg::acc_t      acc_out
);

    logic [7:0]     data_reg;
    logic [7:0]     data_next;
    fqmm_pkg::acc_t acc_reg;
    fqmm_pkg::acc_t acc_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.pop)
        begin
            data_next = next_data;
        end
        else if (ctrl.push && !held && prev_held)
        begin
            data_next = ctrl.value;
        end
    end

    always_comb
    begin
        acc_next = acc_in;
        if (held)
        begin
            if (data_reg < acc_in.lo)
            begin
                acc_next.lo = data_reg;
            end
            if (data_reg > acc_in.hi)
            begin
                acc_next.hi = data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        acc_reg  <= acc_next;
    end

    assign data    = data_reg;
    assign acc_out = acc_reg;

endmodule

FILE: hdl/fifo_queue_min_max_top.sv
// Top level of the byte queue that reports the smallest and largest byte held.
//
// An operation word is taken at a rising edge where start is high and busy is
// low: kind selects enqueue at the tail or dequeue from the head, and value is
// the byte to enqueue. The bytes sit in a chain of QUEUE_DEPTH cells with the
// head in the first cell; a dequeue shifts every cell one place toward the head.
// Each cell also holds one stage of a running minimum and maximum that moves one
// cell per cycle, so the report over all held bytes is ready once the running
// values have passed through every cell of the chain.
// One result word follows each operation: done is high for exactly one cycle
// while status, popped_value, occupancy, is_empty, smallest and largest hold the
// result, in the S_DONE state that follows the S_SCAN walk. busy stays high
// until that cycle ends, so no new operation is taken before the result; the wait
// is set by the walk of the minimum and maximum down the cell chain.
// The receiver cannot stall; the result must be taken in its cycle.
// Reset empties the queue and returns the block to idle; the cell contents are
// left as they are and are never reported before being written.
module fifo_queue_min_max_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       kind,
    input  logic [7:0] value,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] popped_value,
    output logic [4:0] occupancy,
    output logic       is_empty,
    output logic [7:0] smallest,
    output logic [7:0] largest
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);

    fqmm_pkg::state_t     state_reg;
    fqmm_pkg::state_t     state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [SW-1:0]        scan_reg;
    logic [SW-1:0]        scan_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [7:0]           popped_reg;
    logic [7:0]           popped_next;
    logic [CW+4:0]        count_ext;
    logic                 accept;
    logic                 full;
    logic                 empty;
    fqmm_pkg::cell_ctrl_t ctrl;
    logic [QUEUE_DEPTH-1:0] held;
    logic [7:0]           cell_data [QUEUE_DEPTH];
    fqmm_pkg::acc_t       cell_acc [QUEUE_DEPTH];
    fqmm_pkg::acc_t       acc_seed;

    assign accept = start && (state_reg == fqmm_pkg::S_IDLE);
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    assign ctrl.push  = accept && (kind == fqmm_pkg::KIND_ENQ) && !full;
    assign ctrl.pop   = accept && (kind == fqmm_pkg::KIND_DEQ) && !empty;
    assign ctrl.value = value;

    assign acc_seed.lo = fqmm_pkg::BYTE_MAX;
    assign acc_seed.hi = fqmm_pkg::BYTE_MIN;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic           prev_held_w;
            logic [7:0]     next_data_w;
            fqmm_pkg::acc_t acc_in_w;

            assign held[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_first
                assign prev_held_w = 1'b1;
                assign acc_in_w    = acc_seed;
            end
            else
            begin : g_rest
                assign prev_held_w = held[gi-1];
                assign acc_in_w    = cell_acc[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_data_w = 8'h00;
            end
            else
            begin : g_inner
                assign next_data_w = cell_data[gi+1];
            end

            fqmm_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .held      (held[gi]),
                .prev_held (prev_held_w),
                .next_data (next_data_w),
                .acc_in    (acc_in_w),
                .data      (cell_data[gi]),
                .acc_out   (cell_acc[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        case (state_reg)
            fqmm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    scan_next   = '0;
                    state_next  = fqmm_pkg::S_SCAN;
                    status_next = fqmm_pkg::STATUS_OK;
                    popped_next = 8'h00;
                    if (kind == fqmm_pkg::KIND_ENQ)
                    begin
                        if (full)
                        begin
                            status_next = fqmm_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            status_next = fqmm_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next  = count_reg - CW'(1);
                            popped_next = cell_data[0];
                        end
                    end
                end
            end
            fqmm_pkg::S_SCAN:
            begin
                scan_next = scan_reg + SW'(1);
                if (scan_reg == SW'(QUEUE_DEPTH - 1))
                begin
                    state_next = fqmm_pkg::S_DONE;
                end
            end
            fqmm_pkg::S_DONE:
            begin
                state_next = fqmm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fqmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqmm_pkg::S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign count_ext    = {5'b00000, count_reg};
    assign busy         = (state_reg != fqmm_pkg::S_IDLE);
    assign done         = (state_reg == fqmm_pkg::S_DONE);
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = count_ext[4:0];
    assign is_empty     = empty;
    assign smallest     = empty ? 8'h00 : cell_acc[QUEUE_DEPTH-1].lo;
    assign largest      = empty ? 8'h00 : cell_acc[QUEUE_DEPTH-1].hi;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted word did not raise busy.");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == fqmm_pkg::KIND_DEQ && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("Dequeue did not lower the count by one.");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == fqmm_pkg::KIND_ENQ && full)
        |=> (count_reg == $past(count_reg)))
        else $error("Enqueue on a full queue changed the count.");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (smallest == 8'h00 && largest == 8'h00))
        else $error("Empty queue reported a nonzero minimum or maximum.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("Count exceeded the queue depth.");

endmodule
